// ===== hdl/ahe_pkg.sv =====
// ----------------------------------------------------------------------------
// ahe_pkg: shared types and constants for the adaptive Huffman encoder
// Node word layout, tree port bundles and the result item of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ahe_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int TOP_ORDER    = 512;
  localparam int WEIGHT_BITS  = 32;
  localparam int CHUNK_BITS   = 32;
  localparam int MAX_RESULTS  = 9;

  localparam int ORD_W   = $clog2(TOP_ORDER + 1);  // node order incl. the root
  localparam int MEM_AW  = $clog2(TOP_ORDER);      // orders below the root
  localparam int SYM_W   = 8;
  localparam int SYM_AW  = $clog2(SYMBOL_COUNT);
  localparam int LEN_W   = 6;
  localparam int CNT_W   = 5;                       // chunk count, up to 9
  localparam int CSH     = $clog2(CHUNK_BITS);

  typedef logic [ORD_W-1:0]       ord_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;

  localparam ord_t    ORD_TOP    = ORD_W'(TOP_ORDER);
  localparam weight_t WEIGHT_MAX = '1;

  typedef struct packed {
    weight_t         weight;
    ord_t            left;
    ord_t            right;
    logic            leaf;
    logic [SYM_W-1:0] letter;
  } node_t;

  localparam node_t ROOT_RESET = '{weight: '0, left: '0, right: '0, leaf: 1'b1, letter: '0};

  // sequencer to tree store
  typedef struct packed {
    logic  node_rd_en;
    ord_t  node_rd_addr;
    logic  node_wr_en;
    ord_t  node_wr_addr;
    node_t node_wr_data;
    logic  par_rd_en;
    ord_t  par_rd_addr;
    logic  par_wr_en;
    ord_t  par_wr_addr;
    ord_t  par_wr_data;
  } tree_req_t;

  // tree store to sequencer
  typedef struct packed {
    node_t   node_rd;
    ord_t    par_rd;
    weight_t root_weight;
  } tree_rsp_t;

  typedef struct packed {
    logic                  last;
    logic                  frozen;
    logic                  raw;
    logic [LEN_W-1:0]      len;
    logic [CHUNK_BITS-1:0] chunk;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/ahe_tree.sv =====
// ----------------------------------------------------------------------------
// ahe_tree: code tree store
// Node memory for orders below the root, the root node in flops, and the
// parent-link memory. One read and one write per memory per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ahe_tree (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ahe_pkg::tree_req_t req_i,
  output ahe_pkg::tree_rsp_t      rsp_o
);

  ahe_pkg::node_t node_mem [ahe_pkg::TOP_ORDER];
  ahe_pkg::ord_t  par_mem  [ahe_pkg::TOP_ORDER + 1];

  ahe_pkg::node_t node_rd_q;
  ahe_pkg::node_t root_q;
  ahe_pkg::node_t root_rd_q;
  logic           rd_top_q;
  ahe_pkg::ord_t  par_rd_q;

  // node memory, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.node_wr_en && (req_i.node_wr_addr != ahe_pkg::ORD_TOP)) begin
      node_mem[req_i.node_wr_addr[ahe_pkg::MEM_AW-1:0]] <= req_i.node_wr_data;
    end
    if (req_i.node_rd_en) begin
      node_rd_q <= node_mem[req_i.node_rd_addr[ahe_pkg::MEM_AW-1:0]];
    end
  end

  // root node held in flops so that it has a reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q    <= ahe_pkg::ROOT_RESET;
      root_rd_q <= ahe_pkg::ROOT_RESET;
      rd_top_q  <= 1'b0;
    end else begin
      if (req_i.node_wr_en && (req_i.node_wr_addr == ahe_pkg::ORD_TOP)) begin
        root_q <= req_i.node_wr_data;
      end
      if (req_i.node_rd_en) begin
        rd_top_q  <= (req_i.node_rd_addr == ahe_pkg::ORD_TOP);
        root_rd_q <= root_q;
      end
    end
  end

  // parent links, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.par_wr_en) begin
      par_mem[req_i.par_wr_addr] <= req_i.par_wr_data;
    end
    if (req_i.par_rd_en) begin
      par_rd_q <= par_mem[req_i.par_rd_addr];
    end
  end

  assign rsp_o.node_rd     = rd_top_q ? root_rd_q : node_rd_q;
  assign rsp_o.par_rd      = par_rd_q;
  assign rsp_o.root_weight = root_q.weight;

endmodule

`default_nettype wire

// ===== hdl/ahe_seq.sv =====
// ----------------------------------------------------------------------------
// ahe_seq: encoder sequencer
// Walks the leaf path, splits NYT, runs the leader search, swap and weight
// update one step a cycle, then cuts the path into result chunks.
// ----------------------------------------------------------------------------
`default_nettype none

module ahe_seq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [ahe_pkg::SYM_W-1:0] in_symbol_i,
  output ahe_pkg::tree_req_t             tree_req_o,
  input  wire ahe_pkg::tree_rsp_t        tree_rsp_i,
  output logic                           res_valid_o,
  output ahe_pkg::result_t               res_o,
  input  wire logic                      res_ready_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOOK, S_PW, S_PW1, S_PW2, S_UPD,
    S_SPL0, S_SPL1, S_SPL2, S_SPL3,
    S_UF, S_UF1, S_SRCH, S_LP, S_LP1,
    S_SW0, S_SW1, S_SW2, S_SW3, S_RL,
    S_INC, S_INC1, S_INC2, S_ROOT, S_ROOT1,
    S_EM, S_CHS, S_CB, S_PUSH, S_RAW
  } state_e;

  state_e state_q;

  logic [ahe_pkg::SYM_W-1:0] sym_q;
  logic                      known_q;
  ahe_pkg::ord_t             cur_q, start_q, p_q, j_q, jp_q, lead_q, nyt_q;
  ahe_pkg::ord_t             n_q, steps_q, b_q, e_q;
  logic                      pend_q;
  ahe_pkg::weight_t          w_q;
  ahe_pkg::node_t            ta_q, tb_q;
  logic [1:0]                rl_q;
  logic [ahe_pkg::CNT_W-1:0] nch_q, c_q;
  logic [ahe_pkg::CHUNK_BITS-1:0] v_q;

  // symbol table
  logic [ahe_pkg::SYMBOL_COUNT-1:0] present_q;
  ahe_pkg::ord_t                    symnode_mem [ahe_pkg::SYMBOL_COUNT];
  ahe_pkg::ord_t                    symnode_rd_q;
  logic                             sn_wr_en;
  logic [ahe_pkg::SYM_AW-1:0]       sn_wr_addr;
  ahe_pkg::ord_t                    sn_wr_data;

  // reversed path bits
  logic                       path_mem [ahe_pkg::TOP_ORDER];
  logic                       path_rd_q;
  logic                       pm_wr_en;
  logic                       pm_wr_bit;
  logic                       pm_rd_en;
  logic [ahe_pkg::MEM_AW-1:0] pm_rd_addr;

  logic          frozen;
  ahe_pkg::node_t rl_node;
  ahe_pkg::ord_t  rl_slot;
  ahe_pkg::ord_t  nn, nleaf, node_sel;
  ahe_pkg::ord_t  c_base, c_end;
  logic [ahe_pkg::CNT_W-1:0] nch_raw, nch_lim;

  assign frozen   = (tree_rsp_i.root_weight == ahe_pkg::WEIGHT_MAX);
  assign nn       = nyt_q - ahe_pkg::ORD_W'(2);
  assign nleaf    = nyt_q - ahe_pkg::ORD_W'(1);
  assign rl_node  = rl_q[1] ? ta_q : tb_q;
  assign rl_slot  = rl_q[1] ? lead_q : cur_q;
  assign node_sel = (known_q ? symnode_rd_q : nyt_q) > ahe_pkg::ORD_TOP
                    ? ahe_pkg::ORD_TOP : (known_q ? symnode_rd_q : nyt_q);
  assign c_base   = ahe_pkg::ORD_W'(c_q) << ahe_pkg::CSH;
  assign c_end    = ((c_base + ahe_pkg::ORD_W'(ahe_pkg::CHUNK_BITS)) > n_q)
                    ? n_q : (c_base + ahe_pkg::ORD_W'(ahe_pkg::CHUNK_BITS));
  assign nch_raw  = ahe_pkg::CNT_W'((n_q + ahe_pkg::ORD_W'(ahe_pkg::CHUNK_BITS - 1))
                    >> ahe_pkg::CSH);
  assign nch_lim  = known_q ? ahe_pkg::CNT_W'(ahe_pkg::MAX_RESULTS)
                            : ahe_pkg::CNT_W'(ahe_pkg::MAX_RESULTS - 1);

  // memory and port requests
  always_comb begin
    tree_req_o   = '0;
    sn_wr_en     = 1'b0;
    sn_wr_addr   = sym_q;
    sn_wr_data   = nleaf;
    pm_wr_en     = 1'b0;
    pm_wr_bit    = (tree_rsp_i.node_rd.left != cur_q);
    pm_rd_en     = 1'b0;
    pm_rd_addr   = ahe_pkg::MEM_AW'(n_q - ahe_pkg::ORD_W'(1) - b_q);
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.frozen = frozen;
    unique case (state_q)
      S_PW: begin
        tree_req_o.par_rd_en   = (cur_q != ahe_pkg::ORD_TOP) && (n_q != ahe_pkg::ORD_TOP);
        tree_req_o.par_rd_addr = cur_q;
      end
      S_PW1: begin
        tree_req_o.node_rd_en   = (tree_rsp_i.par_rd <= ahe_pkg::ORD_TOP);
        tree_req_o.node_rd_addr = tree_rsp_i.par_rd;
      end
      S_PW2: pm_wr_en = 1'b1;
      S_SPL0: begin
        tree_req_o.node_rd_en   = 1'b1;
        tree_req_o.node_rd_addr = nyt_q;
      end
      S_SPL1: begin
        tree_req_o.node_wr_en         = 1'b1;
        tree_req_o.node_wr_addr       = nyt_q;
        tree_req_o.node_wr_data       = tree_rsp_i.node_rd;
        tree_req_o.node_wr_data.leaf  = 1'b0;
        tree_req_o.node_wr_data.left  = nn;
        tree_req_o.node_wr_data.right = nleaf;
      end
      S_SPL2: begin
        tree_req_o.node_wr_en        = 1'b1;
        tree_req_o.node_wr_addr      = nn;
        tree_req_o.node_wr_data      = ahe_pkg::ROOT_RESET;
        tree_req_o.par_wr_en         = 1'b1;
        tree_req_o.par_wr_addr       = nn;
        tree_req_o.par_wr_data       = nyt_q;
      end
      S_SPL3: begin
        tree_req_o.node_wr_en          = 1'b1;
        tree_req_o.node_wr_addr        = nleaf;
        tree_req_o.node_wr_data        = ahe_pkg::ROOT_RESET;
        tree_req_o.node_wr_data.letter = sym_q;
        tree_req_o.par_wr_en           = 1'b1;
        tree_req_o.par_wr_addr         = nleaf;
        tree_req_o.par_wr_data         = nyt_q;
        sn_wr_en                       = 1'b1;
      end
      S_UF: begin
        tree_req_o.node_rd_en   = 1'b1;
        tree_req_o.node_rd_addr = cur_q;
      end
      S_SRCH: begin
        tree_req_o.node_rd_en   = !(pend_q && (tree_rsp_i.node_rd.weight == w_q))
                                  && (j_q > cur_q);
        tree_req_o.node_rd_addr = j_q;
      end
      S_LP, S_INC1: begin
        tree_req_o.par_rd_en   = 1'b1;
        tree_req_o.par_rd_addr = cur_q;
      end
      S_SW0, S_INC: begin
        tree_req_o.node_rd_en   = 1'b1;
        tree_req_o.node_rd_addr = cur_q;
      end
      S_SW1: begin
        tree_req_o.node_rd_en   = 1'b1;
        tree_req_o.node_rd_addr = lead_q;
      end
      S_SW2: begin
        tree_req_o.node_wr_en   = 1'b1;
        tree_req_o.node_wr_addr = cur_q;
        tree_req_o.node_wr_data = tree_rsp_i.node_rd;
      end
      S_SW3: begin
        tree_req_o.node_wr_en   = 1'b1;
        tree_req_o.node_wr_addr = lead_q;
        tree_req_o.node_wr_data = ta_q;
      end
      S_RL: begin
        // relink one slot: leaf updates the symbol table, else child parents
        sn_wr_addr             = rl_node.letter;
        sn_wr_data             = rl_slot;
        tree_req_o.par_wr_data = rl_slot;
        if (!rl_q[0]) begin
          sn_wr_en               = rl_node.leaf && present_q[rl_node.letter];
          tree_req_o.par_wr_en   = !rl_node.leaf && (rl_node.left <= ahe_pkg::ORD_TOP);
          tree_req_o.par_wr_addr = rl_node.left;
        end else begin
          tree_req_o.par_wr_en   = !rl_node.leaf && (rl_node.right <= ahe_pkg::ORD_TOP);
          tree_req_o.par_wr_addr = rl_node.right;
        end
      end
      S_INC2: begin
        // weight increment of the current node
        tree_req_o.node_wr_en          = 1'b1;
        tree_req_o.node_wr_addr        = cur_q;
        tree_req_o.node_wr_data        = ta_q;
        tree_req_o.node_wr_data.weight = ta_q.weight + 1'b1;
      end
      S_ROOT: begin
        tree_req_o.node_rd_en   = (cur_q == ahe_pkg::ORD_TOP) && !frozen;
        tree_req_o.node_rd_addr = ahe_pkg::ORD_TOP;
      end
      S_ROOT1: begin
        tree_req_o.node_wr_en          = 1'b1;
        tree_req_o.node_wr_addr        = ahe_pkg::ORD_TOP;
        tree_req_o.node_wr_data        = tree_rsp_i.node_rd;
        tree_req_o.node_wr_data.weight = tree_rsp_i.node_rd.weight + 1'b1;
      end
      S_CB: pm_rd_en = (b_q < e_q);
      S_PUSH: begin
        res_valid_o = 1'b1;
        res_o.chunk = v_q;
        res_o.len   = ahe_pkg::LEN_W'(e_q - c_base);
        res_o.last  = known_q && ((c_q + 1'b1) == nch_q);
      end
      S_RAW: begin
        res_valid_o = 1'b1;
        res_o.chunk = ahe_pkg::CHUNK_BITS'(sym_q);
        res_o.len   = ahe_pkg::LEN_W'(ahe_pkg::SYM_W);
        res_o.raw   = 1'b1;
        res_o.last  = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // symbol-to-leaf memory
  always_ff @(posedge clk_i) begin
    if (sn_wr_en) begin
      symnode_mem[sn_wr_addr] <= sn_wr_data;
    end
    if (in_valid_i && in_ready_o) begin
      symnode_rd_q <= symnode_mem[in_symbol_i];
    end
  end

  // path bit memory
  always_ff @(posedge clk_i) begin
    if (pm_wr_en) begin
      path_mem[n_q[ahe_pkg::MEM_AW-1:0]] <= pm_wr_bit;
    end
    if (pm_rd_en) begin
      path_rd_q <= path_mem[pm_rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      present_q <= '0;
      nyt_q     <= ahe_pkg::ORD_TOP;
      pend_q    <= 1'b0;
      rl_q      <= '0;
      c_q       <= '0;
      nch_q     <= '0;
      n_q       <= '0;
      steps_q   <= '0;
      b_q       <= '0;
      e_q       <= '0;
      cur_q     <= '0;
      known_q   <= 1'b0;
      sym_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sym_q   <= in_symbol_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          known_q <= present_q[sym_q];
          state_q <= S_PW;
          n_q     <= '0;
        end
        S_PW: begin
          if (n_q == '0) begin
            start_q <= node_sel;
          end
          // first visit loads the start node; the parent read then repeats
          if (n_q == '0 && cur_q != node_sel) begin
            cur_q <= node_sel;
          end else if ((cur_q == ahe_pkg::ORD_TOP) || (n_q == ahe_pkg::ORD_TOP)) begin
            state_q <= S_UPD;
          end else begin
            state_q <= S_PW1;
          end
        end
        S_PW1: begin
          p_q     <= tree_rsp_i.par_rd;
          state_q <= (tree_rsp_i.par_rd <= ahe_pkg::ORD_TOP) ? S_PW2 : S_UPD;
        end
        S_PW2: begin
          n_q     <= n_q + 1'b1;
          cur_q   <= p_q;
          state_q <= S_PW;
        end
        S_UPD: begin
          nch_q   <= (nch_raw > nch_lim) ? nch_lim
                   : ((known_q && nch_raw == '0) ? ahe_pkg::CNT_W'(1) : nch_raw);
          steps_q <= '0;
          if (frozen) begin
            state_q <= S_EM;
          end else if (known_q) begin
            cur_q   <= start_q;
            state_q <= S_UF;
          end else if (nyt_q >= ahe_pkg::ORD_W'(2)) begin
            state_q <= S_SPL0;
          end else begin
            state_q <= S_EM;
          end
        end
        S_SPL0: state_q <= S_SPL1;
        S_SPL1: state_q <= S_SPL2;
        S_SPL2: state_q <= S_SPL3;
        S_SPL3: begin
          present_q[sym_q] <= 1'b1;
          cur_q            <= nleaf;
          nyt_q            <= nn;
          state_q          <= S_UF;
        end
        S_UF: begin
          state_q <= ((cur_q < ahe_pkg::ORD_TOP) && (steps_q < ahe_pkg::ORD_TOP))
                     ? S_UF1 : S_ROOT;
        end
        S_UF1: begin
          w_q     <= tree_rsp_i.node_rd.weight;
          j_q     <= ahe_pkg::ORD_TOP;
          pend_q  <= 1'b0;
          lead_q  <= cur_q;
          state_q <= S_SRCH;
        end
        S_SRCH: begin
          // leader search: highest order with the same weight
          if (pend_q && (tree_rsp_i.node_rd.weight == w_q)) begin
            lead_q  <= jp_q;
            pend_q  <= 1'b0;
            state_q <= S_LP;
          end else if (j_q > cur_q) begin
            jp_q   <= j_q;
            j_q    <= j_q - 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q  <= 1'b0;
            state_q <= S_LP;
          end
        end
        S_LP: state_q <= S_LP1;
        S_LP1: begin
          state_q <= ((lead_q != cur_q) && (lead_q != tree_rsp_i.par_rd)) ? S_SW0 : S_INC;
        end
        S_SW0: state_q <= S_SW1;
        S_SW1: begin
          ta_q    <= tree_rsp_i.node_rd;
          state_q <= S_SW2;
        end
        S_SW2: begin
          tb_q    <= tree_rsp_i.node_rd;
          state_q <= S_SW3;
        end
        S_SW3: begin
          rl_q    <= '0;
          state_q <= S_RL;
        end
        S_RL: begin
          rl_q <= rl_q + 1'b1;
          if (rl_q == 2'b11) begin
            cur_q   <= lead_q;
            state_q <= S_INC;
          end
        end
        S_INC: state_q <= S_INC1;
        S_INC1: begin
          ta_q    <= tree_rsp_i.node_rd;
          state_q <= S_INC2;
        end
        S_INC2: begin
          cur_q   <= tree_rsp_i.par_rd;
          steps_q <= steps_q + 1'b1;
          state_q <= S_UF;
        end
        S_ROOT: begin
          state_q <= ((cur_q == ahe_pkg::ORD_TOP) && !frozen) ? S_ROOT1 : S_EM;
        end
        S_ROOT1: state_q <= S_EM;
        S_EM: begin
          c_q     <= '0;
          state_q <= (nch_q == '0) ? S_RAW : S_CHS;
        end
        S_CHS: begin
          b_q     <= c_base;
          e_q     <= c_end;
          v_q     <= '0;
          pend_q  <= 1'b0;
          state_q <= S_CB;
        end
        S_CB: begin
          // one path bit per cycle, first bit ends in the top used position
          if (pend_q) begin
            v_q <= {v_q[ahe_pkg::CHUNK_BITS-2:0], path_rd_q};
          end
          if (b_q < e_q) begin
            b_q    <= b_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          if (res_ready_i) begin
            c_q <= c_q + 1'b1;
            if ((c_q + 1'b1) != nch_q) begin
              state_q <= S_CHS;
            end else begin
              state_q <= known_q ? S_IDLE : S_RAW;
            end
          end
        end
        S_RAW: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/adaptive_huffman_encoder_top.sv =====
// ----------------------------------------------------------------------------
// adaptive_huffman_encoder_top: adaptive Huffman (FGK) byte encoder
// Sequencer plus tree store; an output register holds one result beat.
//
//   channel  dir  tdata                         tuser            tlast
//   s_axis   in   symbol[7:0]                   -                -
//   m_axis   out  code_chunk[31:0], len[37:32]  raw[0], frozen[1] last chunk
//
// Per symbol: a walk up the leaf path, then per update level a leader search
// with one node-memory read per order above the node, a swap where needed and
// a weight increment; then the path bits are packed into chunks. The serial
// leader search sets the run time. No clearing pass: the root lives in flops.
// s_axis_tready is high only between symbols; m_axis stalls hold the
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_huffman_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] code_chunk, [37:32] chunk_length
  output logic [1:0]       m_axis_tuser,   // [0] is_raw_symbol, [1] frozen
  output logic             m_axis_tlast
);

  ahe_pkg::tree_req_t tree_req;
  ahe_pkg::tree_rsp_t tree_rsp;
  ahe_pkg::result_t   res, out_q;
  logic               res_valid, res_ready, out_valid_q;

  ahe_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tree_req),
    .rsp_o  (tree_rsp)
  );

  ahe_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_symbol_i (s_axis_tdata),
    .tree_req_o  (tree_req),
    .tree_rsp_i  (tree_rsp),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output beat register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.len, out_q.chunk};
  assign m_axis_tuser  = {out_q.frozen, out_q.raw};
  assign m_axis_tlast  = out_q.last;

`ifndef ASSERT_OFF
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[37:32] <= 6'd32))
    else $error("chunk length above chunk width");

  a_raw_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[37:32] == 6'd8) && m_axis_tlast)
    else $error("raw beat not eight bits or not last");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("input ready while a result is issued");
`endif

endmodule

`default_nettype wire

// ===== test/adaptive_huffman_encoder_top_test.sv =====
// ----------------------------------------------------------------------------
// adaptive_huffman_encoder_top_test: self-checking bench for the FGK encoder
// Random and directed byte streams go in. A behavioral copy of the code tree
// predicts every code beat. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_huffman_encoder_top_test;

  localparam int NODE_CNT = ahe_pkg::TOP_ORDER + 1;

  typedef struct {
    logic [31:0] chunk;
    logic [5:0]  len;
    logic        raw;
    logic        frozen;
    logic        last;
  } code_beat_t;

  // Code tree model plus queue of predicted code beats
  class fgk_scoreboard;
    ahe_pkg::weight_t wt[NODE_CNT];
    int          par[NODE_CNT];
    int          lft[NODE_CNT];
    int          rgt[NODE_CNT];
    bit          is_leaf[NODE_CNT];
    logic [7:0]  letter[NODE_CNT];
    bit          known[ahe_pkg::SYMBOL_COUNT];
    int          sym_node[ahe_pkg::SYMBOL_COUNT];
    int          nyt;
    bit          path[$];
    code_beat_t  pending_beats[$];
    int          errors;

    function new();
      for (int i = 0; i < NODE_CNT; i++) begin
        wt[i] = '0; par[i] = 0; lft[i] = 0; rgt[i] = 0;
        is_leaf[i] = 0; letter[i] = '0;
      end
      for (int i = 0; i < ahe_pkg::SYMBOL_COUNT; i++) begin
        known[i] = 0; sym_node[i] = 0;
      end
      is_leaf[ahe_pkg::TOP_ORDER] = 1;
      nyt = ahe_pkg::TOP_ORDER;
      errors = 0;
    endfunction

    function bit is_frozen();
      return wt[ahe_pkg::TOP_ORDER] == ahe_pkg::WEIGHT_MAX;
    endfunction

    // root-to-node bit path, left is 0
    function void trace_path(int node);
      int cur, p, steps;
      cur = node;
      steps = 0;
      path.delete();
      while (cur != ahe_pkg::TOP_ORDER && steps < ahe_pkg::TOP_ORDER) begin
        p = par[cur];
        if (p > ahe_pkg::TOP_ORDER) break;
        path.push_front(lft[p] == cur ? 1'b0 : 1'b1);
        cur = p;
        steps++;
      end
    endfunction

    function void relink(int slot);
      if (is_leaf[slot]) begin
        if (known[letter[slot]]) sym_node[letter[slot]] = slot;
      end else begin
        if (lft[slot] <= ahe_pkg::TOP_ORDER) par[lft[slot]] = slot;
        if (rgt[slot] <= ahe_pkg::TOP_ORDER) par[rgt[slot]] = slot;
      end
    endfunction

    // parent links stay with their slot
    function void exchange(int a, int b);
      ahe_pkg::weight_t w;
      int t;
      bit c;
      logic [7:0] l;
      w = wt[a]; wt[a] = wt[b]; wt[b] = w;
      t = lft[a]; lft[a] = lft[b]; lft[b] = t;
      t = rgt[a]; rgt[a] = rgt[b]; rgt[b] = t;
      c = is_leaf[a]; is_leaf[a] = is_leaf[b]; is_leaf[b] = c;
      l = letter[a]; letter[a] = letter[b]; letter[b] = l;
      relink(a);
      relink(b);
    endfunction

    function void bump_weights(int start);
      int cur, steps, leader;
      cur = start;
      steps = 0;
      while (cur < ahe_pkg::TOP_ORDER && steps < ahe_pkg::TOP_ORDER) begin
        leader = cur;
        for (int j = ahe_pkg::TOP_ORDER; j > cur; j--) begin
          if (wt[j] == wt[cur]) begin
            leader = j;
            break;
          end
        end
        if (leader != cur && leader != par[cur]) begin
          exchange(cur, leader);
          cur = leader;
        end
        wt[cur] = wt[cur] + 1'b1;
        cur = par[cur];
        steps++;
      end
      if (cur == ahe_pkg::TOP_ORDER && !is_frozen())
        wt[ahe_pkg::TOP_ORDER] = wt[ahe_pkg::TOP_ORDER] + 1'b1;
    endfunction

    // accepted symbol: predict its beats, then update the tree
    function void note_symbol(logic [7:0] sym);
      bit seen, fz;
      int node, nchunks, limit, b0, b1, leaf;
      code_beat_t beat;
      seen = known[sym];
      node = seen ? sym_node[sym] : nyt;
      if (node > ahe_pkg::TOP_ORDER) node = ahe_pkg::TOP_ORDER;
      trace_path(node);
      if (!is_frozen()) begin
        if (seen) begin
          bump_weights(node);
        end else if (nyt >= 2) begin
          leaf = nyt - 1;
          wt[nyt-2] = '0; wt[leaf] = '0;
          par[nyt-2] = nyt; par[leaf] = nyt;
          is_leaf[nyt-2] = 1; is_leaf[leaf] = 1;
          letter[nyt-2] = '0; letter[leaf] = sym;
          lft[nyt-2] = 0; rgt[nyt-2] = 0; lft[leaf] = 0; rgt[leaf] = 0;
          is_leaf[nyt] = 0;
          lft[nyt] = nyt - 2;
          rgt[nyt] = leaf;
          known[sym] = 1;
          sym_node[sym] = leaf;
          nyt = nyt - 2;
          bump_weights(leaf);
        end
      end
      fz = is_frozen();
      limit = seen ? ahe_pkg::MAX_RESULTS : ahe_pkg::MAX_RESULTS - 1;
      nchunks = (path.size() + ahe_pkg::CHUNK_BITS - 1) / ahe_pkg::CHUNK_BITS;
      if (nchunks > limit) nchunks = limit;
      if (seen && nchunks == 0) nchunks = 1;
      for (int c = 0; c < nchunks; c++) begin
        b0 = c * ahe_pkg::CHUNK_BITS;
        b1 = b0 + ahe_pkg::CHUNK_BITS;
        if (b1 > path.size()) b1 = path.size();
        if (b0 > b1) b0 = b1;
        beat.chunk = '0;
        for (int b = b0; b < b1; b++) beat.chunk = {beat.chunk[30:0], path[b]};
        beat.len = 6'(b1 - b0);
        beat.raw = 1'b0;
        beat.frozen = fz;
        beat.last = seen && (c + 1 == nchunks);
        pending_beats.push_back(beat);
      end
      if (!seen) begin
        beat.chunk = {24'h0, sym};
        beat.len = 6'd8;
        beat.raw = 1'b1;
        beat.frozen = fz;
        beat.last = 1'b1;
        pending_beats.push_back(beat);
      end
    endfunction

    function void check_beat(code_beat_t got);
      code_beat_t want;
      if (pending_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected code beat: chunk %h len %0d", got.chunk, got.len);
        return;
      end
      want = pending_beats.pop_front();
      if (want.chunk !== got.chunk || want.len !== got.len || want.raw !== got.raw ||
          want.frozen !== got.frozen || want.last !== got.last) begin
        errors++;
        if (errors <= 10)
          $display({"code beat mismatch: exp chunk %h len %0d raw %b frz %b last %b,",
                    " got chunk %h len %0d raw %b frz %b last %b"},
                   want.chunk, want.len, want.raw, want.frozen, want.last,
                   got.chunk, got.len, got.raw, got.frozen, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;   // [31:0] code_chunk, [37:32] chunk_length
  logic [1:0]  m_axis_tuser;   // [0] is_raw_symbol, [1] frozen
  logic        m_axis_tlast;

  fgk_scoreboard tree_sb = new();
  logic [7:0] sym_pool[20];

  adaptive_huffman_encoder_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  // send one symbol beat after a random gap
  task automatic send_symbol(logic [7:0] sym, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    do @(posedge clk_i); while (!s_axis_tready);
    tree_sb.note_symbol(sym);
  endtask

  // result side: random stalls with stretches of none
  initial begin
    int gap;
    code_beat_t got;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.chunk  = m_axis_tdata[31:0];
      got.len    = m_axis_tdata[37:32];
      got.raw    = m_axis_tuser[0];
      got.frozen = m_axis_tuser[1];
      got.last   = m_axis_tlast;
      tree_sb.check_beat(got);
    end
  end

  // stimulus and end of run
  initial begin
    bit calm;
    logic [7:0] directed[$];
    directed = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h55, 8'hAA,
                 8'h55, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hAA, 8'h80};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_symbol(directed[i], 1'b0);
    foreach (sym_pool[i]) sym_pool[i] = 8'($urandom_range(0, 255));
    calm = 0;
    for (int n = 0; n < 366; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 85)
        send_symbol(sym_pool[$urandom_range(0, 19)], calm);
      else
        send_symbol(8'($urandom_range(0, 255)), calm);
    end
    s_axis_tvalid <= 1'b0;
    while (tree_sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tree_sb.errors == 0 && tree_sb.pending_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
